### hw/rtl/dmdv_pkg.sv
package dmdv_pkg;

  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int DEPTH_BITS_DEF  = 24;
  localparam int VECTOR_BITS_DEF = 16;

  localparam int MAX_HEIGHT = 4096;
  localparam int COORD_W    = 12;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int LAST_W     = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  // Index of the last pixel along one axis for a programmed size.
  // A size of zero counts as one, and sizes above the limit saturate.
  function automatic logic [LAST_W-1:0] last_index(logic [CFG_W-1:0] size,
                                                    int unsigned limit);
    if (size == '0) begin
      return '0;
    end else if (32'(size) > limit) begin
      return LAST_W'(limit - 1);
    end else begin
      return LAST_W'(size - 1'b1);
    end
  endfunction

endpackage

### hw/rtl/dmdv_line_mem.sv
module dmdv_line_mem
  import dmdv_pkg::*;
#(
  parameter int DEPTH  = MAX_WIDTH_DEF,
  parameter int DATA_W = 2 * (DEPTH_BITS_DEF + 2 * VECTOR_BITS_DEF),
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

### hw/rtl/depth_max_dilate_3x3_with_vectors_core.sv
// Max-depth 3x3 dilation with motion vector select.
// Pixels enter on the s_axis channel in raster order, one transaction per
// pixel. Each result leaves on the m_axis channel with its column and row,
// the greatest depth of the edge-clamped 3x3 neighborhood, and the motion
// vector of the first neighbor in scan order that holds it. m_axis_tlast
// marks the result for the bottom right pixel of the frame.
// Frame width and height are set through the cfg port; a write restarts the
// frame at pixel (0,0) and must only happen while the block is idle.
// The first result of a pixel passes the s1, window and output registers. One
// pixel is taken per cycle while each pixel gives at most one result and the
// receiver is ready. A pixel in the last column or last row gives up to two
// results, and the bottom right pixel up to four; they leave the window
// register one per cycle while the receiver is ready; input waits for them.
// The line memory is a single-port-write, single-port-read RAM of
// MAX_WIDTH entries, read once per pixel.
// Reset clears the counters and all valid flags and loads the default
// 1920 by 1080 frame size; the line memory is not cleared.
// When the receiver stalls, the output register holds its result and the
// input keeps flowing until the pipeline in front of it is full.
module depth_max_dilate_3x3_with_vectors_core
  import dmdv_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
  parameter int VECTOR_BITS = VECTOR_BITS_DEF,
  localparam int PIX_W        = DEPTH_BITS + 2 * VECTOR_BITS,
  localparam int IN_W         = ((PIX_W + 7) / 8) * 8,
  localparam int OUT_FIELDS_W = 2 * COORD_W + PIX_W,
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: depth_in, motion_x_in, motion_y_in, zero fill.
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: out_column, out_row, dilated_depth,
  // dilated_motion_x, dilated_motion_y, zero fill.
  output logic [OUT_W-1:0]     m_axis_tdata,
  // Carries frame_done.
  output logic                 m_axis_tlast
);

  localparam int CW = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [VECTOR_BITS-1:0] my;
    logic [VECTOR_BITS-1:0] mx;
    logic [DEPTH_BITS-1:0]  depth;
  } pix_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_t;

  function automatic pix_t pick(pix_t a, pix_t b);
    return (b.depth > a.depth) ? b : a;
  endfunction

  logic [CW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;

  logic             s1_valid;
  pix_t             s1_pix;
  logic [CW-1:0]    s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_last_col;
  logic             s1_last_row;

  line_t            rd_line;
  line_t            wr_line;

  pix_t             win [3][3];
  logic [3:0]       pend;
  logic [CW-1:0]    s2_col;
  logic [ROW_W-1:0] s2_row;

  logic             out_valid;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  pix_t             out_pix;
  logic             out_done;

  logic             in_fire;
  logic             out_free;
  logic             issue;
  logic             s1_go;
  logic [3:0]       sel;
  logic [3:0]       pend_left;
  logic [3:0]       new_pend;
  logic             jsel;
  logic             isel;
  logic [1:0]       rsel [3];
  logic [1:0]       csel [3];
  pix_t             cand [9];
  pix_t             best;
  pix_t             in_pix;

  assign in_pix.depth = s_axis_tdata[DEPTH_BITS-1:0];
  assign in_pix.mx    = s_axis_tdata[DEPTH_BITS +: VECTOR_BITS];
  assign in_pix.my    = s_axis_tdata[DEPTH_BITS + VECTOR_BITS +: VECTOR_BITS];

  // The pending mask lists the results of the window in output order:
  // upper row before lower row, left column before right column.
  assign out_free  = !out_valid || m_axis_tready;
  assign issue     = (pend != '0) && out_free;
  assign sel       = pend & (~pend + 4'd1);
  assign pend_left = pend & ~sel;
  assign s1_go     = s1_valid && ((pend == '0) || (issue && (pend_left == '0)));
  assign s_axis_tready = !s1_valid || s1_go;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  assign new_pend = {s1_last_row & s1_last_col,
                     s1_last_row & (s1_col != '0),
                     (s1_row != '0) & s1_last_col,
                     (s1_row != '0) & (s1_col != '0)};

  assign wr_line.older = rd_line.newer;
  assign wr_line.newer = s1_pix;

  dmdv_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PIX_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col),
    .rd_data (rd_line),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (wr_line)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= CW'(last_index(FRAME_WIDTH_RST, MAX_WIDTH));
      row_last <= ROW_W'(last_index(FRAME_HEIGHT_RST, MAX_HEIGHT));
      col      <= '0;
      row      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          col_last <= CW'(last_index(cfg_data, MAX_WIDTH));
        end
        REG_FRAME_HEIGHT: begin
          row_last <= ROW_W'(last_index(cfg_data, MAX_HEIGHT));
        end
        default: begin
        end
      endcase
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix      <= in_pix;
      s1_col      <= col;
      s1_row      <= row;
      s1_last_col <= (col == col_last);
      s1_last_row <= (row == row_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (s1_go) begin
      pend <= new_pend;
    end else if (issue) begin
      pend <= pend_left;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_line.older;
      win[1][2] <= rd_line.newer;
      win[2][2] <= s1_pix;
      s2_col    <= s1_col;
      s2_row    <= s1_row;
    end
  end

  // Window rows hold rows y-2..y and columns x-2..x. The selects below are
  // the edge-clamped neighbor positions of the result being issued.
  assign jsel = sel[2] | sel[3];
  assign isel = sel[1] | sel[3];

  always_comb begin
    if (jsel) begin
      rsel[0] = (s2_row != '0) ? 2'd1 : 2'd2;
      rsel[1] = 2'd2;
      rsel[2] = 2'd2;
    end else begin
      rsel[0] = (s2_row > ROW_W'(1)) ? 2'd0 : 2'd1;
      rsel[1] = 2'd1;
      rsel[2] = 2'd2;
    end
    if (isel) begin
      csel[0] = (s2_col != '0) ? 2'd1 : 2'd2;
      csel[1] = 2'd2;
      csel[2] = 2'd2;
    end else begin
      csel[0] = (s2_col > CW'(1)) ? 2'd0 : 2'd1;
      csel[1] = 2'd1;
      csel[2] = 2'd2;
    end
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        cand[dy * 3 + dx] = win[rsel[dy]][csel[dx]];
      end
    end
  end

  // Ties go to the earlier neighbor in scan order at every node of the tree.
  assign best = pick(pick(pick(pick(cand[0], cand[1]), pick(cand[2], cand[3])),
                          pick(pick(cand[4], cand[5]), pick(cand[6], cand[7]))),
                     cand[8]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_col  <= COORD_W'(isel ? s2_col : s2_col - 1'b1);
      out_row  <= COORD_W'(jsel ? s2_row : s2_row - 1'b1);
      out_pix  <= best;
      out_done <= isel & jsel;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_pix.my, out_pix.mx, out_pix.depth, out_row, out_col});
  assign m_axis_tlast  = out_done;

endmodule

### hw/rtl/dmdv_checker.sv
module dmdv_checker
  import dmdv_pkg::*;
#(
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
  parameter int VECTOR_BITS = VECTOR_BITS_DEF,
  localparam int PIX_W        = DEPTH_BITS + 2 * VECTOR_BITS,
  localparam int OUT_FIELDS_W = 2 * COORD_W + PIX_W,
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  a_reset_out_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result offered right after reset.");

  a_reset_in_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("Input not ready right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Stalled result changed or dropped.");

  if (OUT_W > OUT_FIELDS_W) begin : g_pad
    a_pad_zero: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:OUT_FIELDS_W] == '0))
      else $error("Fill bits of a result are not zero.");
  end

endmodule

bind depth_max_dilate_3x3_with_vectors_core dmdv_checker #(
  .DEPTH_BITS  (DEPTH_BITS),
  .VECTOR_BITS (VECTOR_BITS)
) u_dmdv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
